/* src/lef_pkg.sv */
`timescale 1ns / 1ps

package lef_pkg;

   // Framing bytes of an HCI LE meta event.
   localparam logic [7:0] PKT_EVENT       = 8'h04;
   localparam logic [7:0] EVT_LE_META     = 8'h3e;

   // Subevent and advertising report codes.
   localparam logic [7:0] SUB_CONN_DONE   = 8'h01;
   localparam logic [7:0] SUB_ADV_REPORT  = 8'h02;
   localparam logic [7:0] NUM_REPORTS_ONE = 8'h01;
   localparam logic [7:0] ADV_TYPE_IND    = 8'h00;
   localparam logic [7:0] STATUS_OK       = 8'h00;

   // AD structure types and where the AD data starts.
   localparam logic [7:0] AD_UUID16       = 8'h03;
   localparam logic [7:0] AD_NAME         = 8'h09;
   localparam logic [7:0] AD_FIRST_OFFSET = 8'd11;
   localparam logic [7:0] AD_LEN_UUID_MIN = 8'd3;
   localparam logic [7:0] AD_LEN_NAME_MIN = 8'd5;

   // Offset within an AD item meaning "no item under way".
   localparam logic [3:0] AD_NO_ITEM      = 4'd15;

   // Register reset values.
   localparam logic [15:0] TARGET_UUID_RESET  = 16'hec00;
   localparam logic [31:0] NAME_PREFIX_RESET  = 32'h6f686365;
   localparam logic [7:0]  LENGTH_LIMIT_RESET = 8'd50;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_TARGET_UUID  = 2'd0,
      REG_NAME_PREFIX  = 2'd1,
      REG_LENGTH_LIMIT = 2'd2
   } reg_index_type;

   // Kinds of result.
   typedef enum logic [1:0] {
      KIND_OTHER  = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_LINK   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] target_uuid;
      logic [31:0] name_prefix;
      logic [7:0]  length_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic        uuid_found;
      logic        name_found;
      logic [47:0] peer_address;
      logic        link_up;
      logic [15:0] link_handle;
      logic [31:0] events_received;
   } result_type;

endpackage

/* src/lef_csr.sv */
`timescale 1ns / 1ps

module lef_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output lef_pkg::cfg_type cfg
);
   import lef_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode; writes to an unused index are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TARGET_UUID:  cfg_in.target_uuid  = csr_wdata[15:0];
            REG_NAME_PREFIX:  cfg_in.name_prefix  = csr_wdata;
            REG_LENGTH_LIMIT: cfg_in.length_limit = csr_wdata[7:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_uuid  <= TARGET_UUID_RESET;
         cfg_ff.name_prefix  <= NAME_PREFIX_RESET;
         cfg_ff.length_limit <= LENGTH_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/lef_parser.sv */
`timescale 1ns / 1ps

module lef_parser (
   input  logic                clock,
   input  logic                reset,
   input  lef_pkg::cfg_type    cfg,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                emit,
   output lef_pkg::result_type result
);
   import lef_pkg::*;

   typedef enum logic [3:0] {
      WAIT_IND  = 4'b0001,
      WAIT_CODE = 4'b0010,
      WAIT_LEN  = 4'b0100,
      PARAMS    = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  found_ff, found_in;
   logic [47:0] addr_ff, addr_in;
   logic        link_ff, link_in;
   logic [15:0] handle_ff, handle_in;

   logic [7:0]  len_ff, len_in;
   logic [7:0]  idx_ff, idx_in;
   logic [31:0] held_ff, held_in;
   logic [7:0]  ad_next_ff, ad_next_in;
   logic [7:0]  ad_len_ff, ad_len_in;
   logic [7:0]  ad_type_ff, ad_type_in;
   logic [3:0]  progress_ff, progress_in;
   logic        fits_ff, fits_in;
   logic [31:0] ad_value_ff, ad_value_in;
   logic [1:0]  pflags_ff, pflags_in;
   logic [47:0] paddr_ff, paddr_in;

   logic        finish;
   logic [1:0]  kind;
   logic [8:0]  nxt_start;
   logic [3:0]  r;

   // Frame walk: header bytes, then parameter bytes and the AD structures.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      addr_in     = addr_ff;
      link_in     = link_ff;
      handle_in   = handle_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      held_in     = held_ff;
      ad_next_in  = ad_next_ff;
      ad_len_in   = ad_len_ff;
      ad_type_in  = ad_type_ff;
      progress_in = progress_ff;
      fits_in     = fits_ff;
      ad_value_in = ad_value_ff;
      pflags_in   = pflags_ff;
      paddr_in    = paddr_ff;
      finish      = 1'b0;
      kind        = KIND_OTHER;
      nxt_start   = {1'b0, idx_ff} + 9'd1 + {1'b0, rx_byte};
      r           = progress_ff + 4'd1;

      unique case (state_ff)
         WAIT_IND: begin
            state_in = (rx_byte == PKT_EVENT) ? WAIT_CODE : WAIT_IND;
         end
         WAIT_CODE: begin
            state_in = (rx_byte == EVT_LE_META) ? WAIT_LEN : WAIT_IND;
         end
         WAIT_LEN: begin
            if (rx_byte > cfg.length_limit) begin
               state_in = WAIT_IND;
            end else begin
               len_in      = rx_byte;
               idx_in      = 8'd0;
               held_in     = 32'd0;
               ad_next_in  = AD_FIRST_OFFSET;
               ad_len_in   = 8'd0;
               ad_type_in  = 8'd0;
               progress_in = AD_NO_ITEM;
               fits_in     = 1'b0;
               ad_value_in = 32'd0;
               pflags_in   = 2'd0;
               paddr_in    = 48'd0;
               state_in    = PARAMS;
               // An empty frame is complete as soon as its length arrives.
               finish      = (rx_byte == 8'd0);
            end
         end
         PARAMS: begin
            // First four parameter bytes are kept for decoding.
            case (idx_ff)
               8'd0:    held_in[7:0]   = rx_byte;
               8'd1:    held_in[15:8]  = rx_byte;
               8'd2:    held_in[23:16] = rx_byte;
               8'd3:    held_in[31:24] = rx_byte;
               default: held_in        = held_ff;
            endcase
            // Device address, stored byte reversed.
            case (idx_ff)
               8'd4:    paddr_in[47:40] = rx_byte;
               8'd5:    paddr_in[39:32] = rx_byte;
               8'd6:    paddr_in[31:24] = rx_byte;
               8'd7:    paddr_in[23:16] = rx_byte;
               8'd8:    paddr_in[15:8]  = rx_byte;
               8'd9:    paddr_in[7:0]   = rx_byte;
               default: paddr_in        = paddr_ff;
            endcase
            // AD structures: length byte opens an item, then type and data.
            if (idx_ff >= AD_FIRST_OFFSET) begin
               if (idx_ff == ad_next_ff) begin
                  ad_len_in   = rx_byte;
                  ad_next_in  = nxt_start[8] ? 8'hff : nxt_start[7:0];
                  fits_in     = ({1'b0, idx_ff} + {1'b0, rx_byte})
                                <= ({1'b0, len_ff} - 9'd1);
                  progress_in = 4'd0;
                  ad_type_in  = 8'd0;
                  ad_value_in = 32'd0;
               end else if (progress_ff != AD_NO_ITEM) begin
                  progress_in = r;
                  if (r == 4'd1) begin
                     ad_type_in = rx_byte;
                  end else begin
                     case (r)
                        4'd2:    ad_value_in[7:0]   = rx_byte;
                        4'd3:    ad_value_in[15:8]  = rx_byte;
                        4'd4:    ad_value_in[23:16] = rx_byte;
                        4'd5:    ad_value_in[31:24] = rx_byte;
                        default: ad_value_in        = ad_value_ff;
                     endcase
                     if (fits_ff) begin
                        if (r == 4'd3 && ad_type_ff == AD_UUID16 &&
                            ad_len_ff >= AD_LEN_UUID_MIN &&
                            ad_value_in[15:0] == cfg.target_uuid) begin
                           pflags_in[0] = 1'b1;
                        end
                        if (r == 4'd5 && ad_type_ff == AD_NAME &&
                            ad_len_ff >= AD_LEN_NAME_MIN &&
                            ad_value_in == cfg.name_prefix) begin
                           pflags_in[1] = 1'b1;
                        end
                     end
                  end
               end
            end
            if (({1'b0, idx_ff} + 9'd1) >= {1'b0, len_ff}) begin
               finish = 1'b1;
            end else begin
               idx_in = idx_ff + 8'd1;
            end
         end
         default: begin
            state_in = WAIT_IND;
         end
      endcase

      // Frame completion: count it and decode the subevent.
      if (finish) begin
         state_in = WAIT_IND;
         count_in = count_ff + 32'd1;
         if (len_in >= 8'd2) begin
            if (held_in[7:0] == SUB_ADV_REPORT && held_in[15:8] == NUM_REPORTS_ONE &&
                held_in[23:16] == ADV_TYPE_IND) begin
               found_in = pflags_in;
               addr_in  = paddr_in;
               kind     = KIND_REPORT;
            end else if (held_in[7:0] == SUB_CONN_DONE && !link_ff) begin
               link_in   = (held_in[15:8] == STATUS_OK);
               handle_in = held_in[31:16];
               kind      = KIND_LINK;
            end
         end
      end
   end

   assign emit                   = finish;
   assign result.event_kind      = kind;
   assign result.uuid_found      = found_in[0];
   assign result.name_found      = found_in[1];
   assign result.peer_address    = addr_in;
   assign result.link_up         = link_in;
   assign result.link_handle     = handle_in;
   assign result.events_received = count_in;

   // Control and visible state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= WAIT_IND;
         count_ff  <= 32'd0;
         found_ff  <= 2'd0;
         addr_ff   <= 48'd0;
         link_ff   <= 1'b0;
         handle_ff <= 16'd0;
      end else if (step) begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         addr_ff   <= addr_in;
         link_ff   <= link_in;
         handle_ff <= handle_in;
      end
   end

   // Per-frame working registers, all loaded when the length arrives.
   always_ff @(posedge clock) begin
      if (step) begin
         len_ff      <= len_in;
         idx_ff      <= idx_in;
         held_ff     <= held_in;
         ad_next_ff  <= ad_next_in;
         ad_len_ff   <= ad_len_in;
         ad_type_ff  <= ad_type_in;
         progress_ff <= progress_in;
         fits_ff     <= fits_in;
         ad_value_ff <= ad_value_in;
         pflags_ff   <= pflags_in;
         paddr_ff    <= paddr_in;
      end
   end

endmodule

/* src/lef_rsp_reg.sv */
`timescale 1ns / 1ps

module lef_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lef_pkg::result_type load_data,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lef_pkg::result_type rsp_data
);
   import lef_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The register can take a new item when empty or being emptied.
   assign free      = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

/* src/le_event_deframer_and_filter.sv */
`timescale 1ns / 1ps

// LE meta event deframer and filter. Takes one received link byte per clock
// and returns one result for every complete LE meta event frame (0x04, 0x3e,
// length), carrying the frame count, the scan match flags and address of the
// last advertising report, and the link state and handle. Each byte goes
// through an input register and is decoded combinationally into the result
// register, so a byte can be accepted on every cycle; the result of a frame's
// last byte is loaded into the result register as that byte leaves the input
// register. A byte that completes a frame waits in the input register while
// the previous result is still held on rsp_stall; other bytes keep flowing.
// Configuration registers are written via the csr_ port, which is always ready.
module le_event_deframer_and_filter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic        rsp_uuid_found,
   output logic        rsp_name_found,
   output logic [47:0] rsp_peer_address,
   output logic        rsp_link_up,
   output logic [15:0] rsp_link_handle,
   output logic [31:0] rsp_events_received,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import lef_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       emit;
   logic       out_free;
   logic       advance;
   logic       accept;

   lef_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register: the held item moves on unless its result cannot be placed.
   assign advance     = in_valid_ff && (!emit || out_free);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   lef_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   lef_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_data (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_event_kind      = rsp_data.event_kind;
   assign rsp_uuid_found      = rsp_data.uuid_found;
   assign rsp_name_found      = rsp_data.name_found;
   assign rsp_peer_address    = rsp_data.peer_address;
   assign rsp_link_up         = rsp_data.link_up;
   assign rsp_link_handle     = rsp_data.link_handle;
   assign rsp_events_received = rsp_data.events_received;

`ifndef SYNTHESIS
   // A completed frame always shows up in the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_valid)
      else $error("completed frame did not reach the result register");

   // A byte held back in the input register is neither lost nor altered.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input item was lost or changed");

   // Consecutive results count frames one by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && emit && rsp_valid |=>
         rsp_events_received == $past(rsp_events_received) + 32'd1)
      else $error("frame count did not advance by one");

   // Once the link is up, it stays up.
   a_link_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && emit && rsp_valid && rsp_link_up |=> rsp_link_up)
      else $error("link_up cleared after being set");
`endif

endmodule

/* verif/tb_le_event_deframer_and_filter.sv */
`timescale 1ns / 1ps

module tb_le_event_deframer_and_filter;
   import lef_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int IDLE_PCT       = 19;
   localparam int WATCHDOG_LIMIT = 2000;

   // Where the byte stream stands within an LE meta event frame.
   typedef enum logic [1:0] {
      AWAIT_PKT,
      AWAIT_CODE,
      AWAIT_LEN,
      IN_PARAMS
   } frame_state_type;

   // Tracks the deframer and filter state and holds the results still to come.
   class le_frame_scoreboard;
      logic [15:0]     uuid_reg;
      logic [31:0]     prefix_reg;
      logic [7:0]      limit_reg;

      frame_state_type state;
      logic [7:0]      evt_len;
      logic [31:0]     frame_cnt;
      logic [31:0]     hdr;
      int              ad_start;
      logic [7:0]      ad_len;
      logic [7:0]      ad_type;
      logic [3:0]      ad_off;
      logic [1:0]      flags;
      logic [47:0]     addr;
      logic            link;
      logic [15:0]     handle;
      int              idx;
      bit              fits;
      logic [31:0]     ad_val;
      logic [1:0]      pend_flags;
      logic [47:0]     pend_addr;

      result_type      expected_q[$];
      int              errors;

      function new();
         uuid_reg   = TARGET_UUID_RESET;
         prefix_reg = NAME_PREFIX_RESET;
         limit_reg  = LENGTH_LIMIT_RESET;
         state      = AWAIT_PKT;
         evt_len    = '0;
         frame_cnt  = '0;
         flags      = '0;
         addr       = '0;
         link       = 1'b0;
         handle     = '0;
         errors     = 0;
         clear_frame();
      endfunction

      function void set_reg(reg_index_type index, logic [31:0] value);
         case (index)
            REG_TARGET_UUID:  uuid_reg   = value[15:0];
            REG_NAME_PREFIX:  prefix_reg = value;
            REG_LENGTH_LIMIT: limit_reg  = value[7:0];
            default: ;
         endcase
      endfunction

      function void clear_frame();
         idx        = 0;
         hdr        = '0;
         ad_start   = AD_FIRST_OFFSET;
         ad_len     = '0;
         ad_type    = '0;
         ad_off     = AD_NO_ITEM;
         fits       = 1'b0;
         ad_val     = '0;
         pend_flags = '0;
         pend_addr  = '0;
      endfunction

      // A frame has ended: update the held values and queue the result.
      function void close_frame();
         result_type r;
         kind_type   kind;
         kind      = KIND_OTHER;
         frame_cnt = frame_cnt + 1;
         if (evt_len >= 2) begin
            if (hdr[7:0] == SUB_ADV_REPORT && hdr[15:8] == NUM_REPORTS_ONE &&
                hdr[23:16] == ADV_TYPE_IND) begin
               flags = pend_flags;
               addr  = pend_addr;
               kind  = KIND_REPORT;
            end else if (hdr[7:0] == SUB_CONN_DONE && !link) begin
               link   = (hdr[15:8] == STATUS_OK);
               handle = hdr[31:16];
               kind   = KIND_LINK;
            end
         end
         state             = AWAIT_PKT;
         r.event_kind      = kind;
         r.uuid_found      = flags[0];
         r.name_found      = flags[1];
         r.peer_address    = addr;
         r.link_up         = link;
         r.link_handle     = handle;
         r.events_received = frame_cnt;
         expected_q.push_back(r);
      endfunction

      // One byte of the AD data; an item only counts when it lies wholly inside the frame.
      function void walk_ad(int i, logic [7:0] b);
         int r;
         int nxt;
         if (i == ad_start) begin
            nxt      = i + 1 + b;
            ad_len   = b;
            ad_start = (nxt > 255) ? 255 : nxt;
            fits     = (i + b) <= (int'(evt_len) - 1);
            ad_off   = '0;
            ad_type  = '0;
            ad_val   = '0;
            return;
         end
         if (ad_off == AD_NO_ITEM)
            return;
         ad_off = ad_off + 4'd1;
         r      = int'(ad_off);
         if (r == 1) begin
            ad_type = b;
            return;
         end
         if (r >= 2 && r <= 5)
            ad_val |= 32'(b) << (8 * (r - 2));
         if (!fits)
            return;
         if (r == 3 && ad_type == AD_UUID16 && ad_len >= AD_LEN_UUID_MIN &&
             ad_val[15:0] == uuid_reg)
            pend_flags[0] = 1'b1;
         if (r == 5 && ad_type == AD_NAME && ad_len >= AD_LEN_NAME_MIN &&
             ad_val == prefix_reg)
            pend_flags[1] = 1'b1;
      endfunction

      // Notes one accepted input item.
      function void note_byte(logic [7:0] b);
         int i;
         case (state)
            AWAIT_PKT: begin
               state = (b == PKT_EVENT) ? AWAIT_CODE : AWAIT_PKT;
            end
            AWAIT_CODE: begin
               state = (b == EVT_LE_META) ? AWAIT_LEN : AWAIT_PKT;
            end
            AWAIT_LEN: begin
               if (b > limit_reg) begin
                  state = AWAIT_PKT;
               end else begin
                  evt_len = b;
                  clear_frame();
                  state = IN_PARAMS;
                  if (b == 0)
                     close_frame();
               end
            end
            default: begin
               i = idx;
               if (i < 4)
                  hdr[8*i +: 8] = b;
               if (i >= 4 && i <= 9)
                  pend_addr[8*(9-i) +: 8] = b;
               if (i >= 11)
                  walk_ad(i, b);
               if (i + 1 >= evt_len)
                  close_frame();
               else
                  idx = (i + 1) & 255;
            end
         endcase
      endfunction

      // Compares an accepted result with the oldest one still awaited.
      function void check_result(result_type got);
         result_type exp;
         if (expected_q.size() == 0) begin
            $error("result item arrived with no frame completed");
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.event_kind !== exp.event_kind) begin
            $error("event_kind: expected %0d, got %0d", exp.event_kind, got.event_kind);
            errors++;
         end
         if (got.uuid_found !== exp.uuid_found) begin
            $error("uuid_found: expected %0d, got %0d", exp.uuid_found, got.uuid_found);
            errors++;
         end
         if (got.name_found !== exp.name_found) begin
            $error("name_found: expected %0d, got %0d", exp.name_found, got.name_found);
            errors++;
         end
         if (got.peer_address !== exp.peer_address) begin
            $error("peer_address: expected %h, got %h", exp.peer_address, got.peer_address);
            errors++;
         end
         if (got.link_up !== exp.link_up) begin
            $error("link_up: expected %0d, got %0d", exp.link_up, got.link_up);
            errors++;
         end
         if (got.link_handle !== exp.link_handle) begin
            $error("link_handle: expected %h, got %h", exp.link_handle, got.link_handle);
            errors++;
         end
         if (got.events_received !== exp.events_received) begin
            $error("events_received: expected %0d, got %0d",
                   exp.events_received, got.events_received);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic        rsp_uuid_found;
   logic        rsp_name_found;
   logic [47:0] rsp_peer_address;
   logic        rsp_link_up;
   logic [15:0] rsp_link_handle;
   logic [31:0] rsp_events_received;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   le_frame_scoreboard sb = new();
   result_type         rsp_seen;
   logic               calm = 1'b0;
   int                 sent_count = 0;
   int                 quiet_cycles = 0;
   logic [7:0]         tx_q[$];
   logic [7:0]         body_q[$];

   le_event_deframer_and_filter dut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   assign rsp_seen = {rsp_event_kind, rsp_uuid_found, rsp_name_found, rsp_peer_address,
                      rsp_link_up, rsp_link_handle, rsp_events_received};

   // The result side stalls at random, except during the calm stretch.
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_seen);

   // Ends the run when no handshake of any kind has completed for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_le_event_deframer_and_filter NOT OK");
         $finish;
      end
   end

   // Offers one item, idling a random number of cycles first, and waits until it is taken.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
      sent_count++;
   endtask

   task automatic send_queue();
      foreach (tx_q[k])
         send_byte(tx_q[k]);
      tx_q.delete();
   endtask

   task automatic write_reg(input reg_index_type index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(index, value);
   endtask

   // Brings the block to rest between frames, then writes all three registers.
   task automatic reconfigure(input logic [15:0] uuid, input logic [31:0] prefix,
                              input logic [7:0] limit);
      while (sb.state != AWAIT_PKT)
         send_byte(8'h00);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      write_reg(REG_TARGET_UUID, {16'h0000, uuid});
      write_reg(REG_NAME_PREFIX, prefix);
      write_reg(REG_LENGTH_LIMIT, {24'h000000, limit});
      csr_valid <= 1'b0;
   endtask

   // Parameter length within the current limit, now and then the limit itself.
   function automatic int pick_len(int lo, int hi);
      int v;
      if ($urandom_range(99) < 5)
         return int'(sb.limit_reg);
      v = $urandom_range(hi, lo);
      return (v > sb.limit_reg) ? int'(sb.limit_reg) : v;
   endfunction

   // Appends one AD structure whose leading data bytes come from lead.
   function automatic void push_ad(logic [7:0] typ, int len, logic [31:0] lead, int lead_n);
      body_q.push_back(len[7:0]);
      if (len >= 1)
         body_q.push_back(typ);
      for (int k = 0; k < len - 1; k++)
         body_q.push_back((k < lead_n) ? lead[8*k +: 8] : 8'($urandom_range(255)));
   endfunction

   // Wraps the body in a header; a few frames carry a length above the limit.
   function automatic void emit_frame();
      int hl;
      if (sb.limit_reg != 8'd255 && $urandom_range(99) < 6)
         hl = $urandom_range(255, int'(sb.limit_reg) + 1);
      else
         hl = body_q.size();
      tx_q.push_back(PKT_EVENT);
      tx_q.push_back(EVT_LE_META);
      tx_q.push_back(hl[7:0]);
      foreach (body_q[k])
         tx_q.push_back(body_q[k]);
      body_q.delete();
   endfunction

   // Advertising report with a random mix of AD structures, cut at the frame length.
   function automatic void queue_adv();
      int tl;
      tl = pick_len(11, 45);
      body_q.push_back(SUB_ADV_REPORT);
      body_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : NUM_REPORTS_ONE);
      body_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ADV_TYPE_IND);
      repeat (8) body_q.push_back(8'($urandom_range(255)));
      while (body_q.size() < tl) begin
         case ($urandom_range(3))
            0: push_ad(AD_UUID16, ($urandom_range(4) == 0) ? $urandom_range(5, 1) : 3,
                       ($urandom_range(99) < 70) ? {16'h0000, sb.uuid_reg} : $urandom, 2);
            1: push_ad(AD_NAME, ($urandom_range(4) == 0) ? $urandom_range(4, 1)
                                                         : $urandom_range(8, 5),
                       ($urandom_range(99) < 70) ? sb.prefix_reg : $urandom, 4);
            2: body_q.push_back(8'h00);
            default: push_ad(8'($urandom_range(255)), $urandom_range(4, 1), $urandom, 0);
         endcase
      end
      while (body_q.size() > tl)
         void'(body_q.pop_back());
      emit_frame();
   endfunction

   // Connection complete; status zero only now and then so the link stays down a while.
   function automatic void queue_conn();
      int tl;
      tl = pick_len(2, 12);
      body_q.push_back(SUB_CONN_DONE);
      body_q.push_back(($urandom_range(5) == 0) ? STATUS_OK : 8'($urandom_range(255)));
      repeat (10) body_q.push_back(8'($urandom_range(255)));
      while (body_q.size() > tl)
         void'(body_q.pop_back());
      emit_frame();
   endfunction

   // Other subevents and short reports with random bytes in place of AD structures.
   function automatic void queue_misc();
      int tl;
      tl = pick_len(0, 14);
      if ($urandom_range(1) == 0) begin
         body_q.push_back(SUB_ADV_REPORT);
         body_q.push_back(NUM_REPORTS_ONE);
         body_q.push_back(ADV_TYPE_IND);
      end
      while (body_q.size() < tl)
         body_q.push_back(8'($urandom_range(255)));
      while (body_q.size() > tl)
         void'(body_q.pop_back());
      emit_frame();
   endfunction

   // Stray bytes and broken headers.
   function automatic void queue_noise();
      case ($urandom_range(2))
         0: repeat ($urandom_range(4, 1)) tx_q.push_back(8'($urandom_range(255)));
         1: begin
            tx_q.push_back(PKT_EVENT);
            tx_q.push_back(8'($urandom_range(255)));
         end
         default: begin
            tx_q.push_back(PKT_EVENT);
            tx_q.push_back(PKT_EVENT);
            tx_q.push_back(EVT_LE_META);
         end
      endcase
   endfunction

   task automatic run_phase(input int quota);
      int start;
      int pick;
      start = sent_count;
      while (sent_count - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 50)
            queue_adv();
         else if (pick < 65)
            queue_conn();
         else if (pick < 82)
            queue_misc();
         else
            queue_noise();
         send_queue();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Header errors, a 0x04 in place of the event code, zero length, a dropped
      // frame, a one-byte frame and a connection with a failing status.
      tx_q = {8'hFF, 8'h04, 8'h04, 8'h3E,
              8'h04, 8'h3E, 8'h00,
              8'h04, 8'h3E, 8'hFF,
              8'h04, 8'h3E, 8'h01, 8'h01,
              8'h04, 8'h3E, 8'h05, 8'h01, 8'h07, 8'h34, 8'h12, 8'h00};
      send_queue();

      run_phase(150);

      // Widest limit, with a stretch where neither side idles.
      reconfigure(16'h0000, 32'hFFFF_FFFF, 8'd255);
      calm <= 1'b1;
      run_phase(130);
      calm <= 1'b0;

      // Nothing but zero-length frames gets through.
      reconfigure(16'hFFFF, 32'h0000_0000, 8'd0);
      run_phase(40);

      // Reports cut off just after the first AD byte.
      reconfigure(16'($urandom), $urandom, 8'd12);
      run_phase(100);

      reconfigure(16'($urandom), $urandom, 8'($urandom_range(80, 11)));
      run_phase(130);

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_le_event_deframer_and_filter OK");
      else
         $display("tb_le_event_deframer_and_filter NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
src/lef_pkg.sv
src/lef_csr.sv
src/lef_parser.sv
src/lef_rsp_reg.sv
src/le_event_deframer_and_filter.sv
verif/tb_le_event_deframer_and_filter.sv
